// ===== design/mtd_pkg.sv =====
// Shared types, codes and helper functions for the Morse timing decoder.
`timescale 1ns / 1ps
package mtd_pkg;

    // Event codes carried in the input tuser field.
    localparam logic [1:0] OP_DOWN = 2'd0;
    localparam logic [1:0] OP_UP   = 2'd1;
    localparam logic [1:0] OP_POLL = 2'd2;

    // Result kinds carried in the output tuser field.
    localparam logic [1:0] KIND_CHAR    = 2'd0;
    localparam logic [1:0] KIND_RELEASE = 2'd1;
    localparam logic [1:0] KIND_CAL_ERR = 2'd2;
    localparam logic [1:0] KIND_INVALID = 2'd3;

    localparam int          MAX_SYMBOLS = 7;
    localparam int          TREE_LIMIT  = (((2 << MAX_SYMBOLS) - 2) > 254) ? 254
                                          : ((2 << MAX_SYMBOLS) - 2);
    localparam logic [7:0]  NODE_DEEP   = 8'hFF;
    localparam logic [15:0] LEN_SAT     = 16'hFFFF;
    localparam logic [15:0] TOL_RESET   = 16'd100;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // One queued event outcome: a main word, optionally preceded by a release word.
    typedef struct packed {
        logic       rel;
        logic [1:0] kind;
        logic [7:0] index;
    } desc_t;

    // Elapsed ticks between two stamps, saturating when the wrap count does not fit.
    function automatic logic [15:0] span(input logic [15:0] s, input logic [15:0] e,
                                         input logic [1:0] wraps);
        logic [15:0] diff;
        begin
            diff = e - s;
            if (e >= s && wraps == 2'd0)
                span = diff;
            else if (e < s && wraps == 2'd1)
                span = diff;
            else
                span = LEN_SAT;
        end
    endfunction

    // Two durations match when their absolute difference is below the tolerance.
    function automatic logic close_enough(input logic [15:0] x, input logic [15:0] y,
                                          input logic [15:0] tol);
        logic [15:0] d;
        begin
            d = (x < y) ? (y - x) : (x - y);
            close_enough = d < tol;
        end
    endfunction

    // Step down the tree: left child for a dit, right child for a dah.
    function automatic logic [7:0] step_tree(input logic [7:0] node, input logic dah);
        logic [9:0] nxt;
        begin
            nxt = {1'b0, node, 1'b0} + (dah ? 10'd2 : 10'd1);
            if (node == NODE_DEEP || nxt > 10'(TREE_LIMIT))
                step_tree = NODE_DEEP;
            else
                step_tree = nxt[7:0];
        end
    endfunction

endpackage

// ===== design/morse_timing_decoder.sv =====
// Top level of the Morse key timing decoder.
`timescale 1ns / 1ps
// The decoder takes one event word per clock cycle while the queue has room: a
// key down edge, a key up edge or a poll, each with its tick stamp and wrap count.
// The first two nonzero pulses calibrate the dit and dah lengths; later pulses are
// matched against them within the tolerance register and walk the Morse tree, and
// a poll made after a gap of at least a dah, or within the tolerance of one, emits
// the tree index, preceded by a release word when the same index was sent last
// time. Each event is classified in the cycle it is accepted, so the input side
// runs at that rate. Outcomes wait in a four-entry queue in front of a registered
// output stage, which sends one word per cycle while the receiver is ready; an
// outcome carrying a release marker sends a release word and then its main word.
// Such outcomes need a key up edge between two polls, so they never arrive on
// consecutive input words, and the queue lets the input keep going while the
// output is stalled, until it fills. The tolerance register may be written at
// any time the block is idle and takes effect on the next event.
module morse_timing_decoder (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,    // tolerance
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // timestamp[15:0], wraps[17:16], zero pad
    input  logic [1:0]  s_axis_tuser,   // op[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // tree_index[7:0]
    output logic [1:0]  m_axis_tuser,   // kind[1:0]
    output logic        m_axis_tlast
);
    import mtd_pkg::*;

    logic  accept;
    logic  push;
    desc_t push_desc;
    logic  full;
    logic  empty;
    logic  pop;
    desc_t head;

    // A word is taken whenever the queue has room, whatever the output side does.
    assign s_axis_tready = !full;
    assign accept        = s_axis_tvalid && s_axis_tready;

    mtd_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .accept      (accept),
        .op          (s_axis_tuser),
        .timestamp   (s_axis_tdata[15:0]),
        .wraps       (s_axis_tdata[17:16]),
        .push        (push),
        .push_desc   (push_desc)
    );

    mtd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_desc (push_desc),
        .full      (full),
        .empty     (empty),
        .pop       (pop),
        .head      (head)
    );

    mtd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .empty     (empty),
        .head      (head),
        .pop       (pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_kind  (m_axis_tuser),
        .out_index (m_axis_tdata),
        .out_last  (m_axis_tlast)
    );

endmodule

// ===== design/mtd_queue.sv =====
// Short first-in first-out queue of event outcomes between front and back.
`timescale 1ns / 1ps
module mtd_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  mtd_pkg::desc_t push_desc,
    output logic          full,
    output logic          empty,
    input  logic          pop,
    output mtd_pkg::desc_t head
);
    import mtd_pkg::*;

    desc_t                 mem_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_AW:0]     count_reg, count_next;
    logic                  do_push, do_pop;

    assign full    = (count_reg == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_desc;
    end

endmodule

// ===== design/mtd_front.sv =====
// Front end: accepts key events, keeps the timing state and classifies each event.
`timescale 1ns / 1ps
module mtd_front (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cfg_wr_en,
    input  logic [15:0]    cfg_wr_data,
    input  logic           accept,
    input  logic [1:0]     op,
    input  logic [15:0]    timestamp,
    input  logic [1:0]     wraps,
    output logic           push,
    output mtd_pkg::desc_t push_desc
);
    import mtd_pkg::*;

    logic [15:0] tolerance_reg;
    logic [15:0] down_stamp_reg, down_stamp_next;
    logic [15:0] up_stamp_reg, up_stamp_next;
    logic [15:0] dit_length_reg, dit_length_next;
    logic [15:0] dah_length_reg, dah_length_next;
    logic        in_gap_reg, in_gap_next;
    logic        end_sent_reg, end_sent_next;
    logic [7:0]  node_index_reg, node_index_next;
    logic [7:0]  previous_index_reg, previous_index_next;

    always_comb
    begin
        logic [15:0] pulse;
        logic [15:0] gap;
        down_stamp_next     = down_stamp_reg;
        up_stamp_next       = up_stamp_reg;
        dit_length_next     = dit_length_reg;
        dah_length_next     = dah_length_reg;
        in_gap_next         = in_gap_reg;
        end_sent_next       = end_sent_reg;
        node_index_next     = node_index_reg;
        previous_index_next = previous_index_reg;
        push                = 1'b0;
        push_desc           = '0;
        pulse               = span(down_stamp_reg, timestamp, wraps);
        gap                 = span(up_stamp_reg, timestamp, wraps);

        if (accept)
        begin
            case (op)
                OP_DOWN:
                begin
                    in_gap_next     = 1'b0;
                    down_stamp_next = timestamp;
                end
                OP_UP:
                begin
                    in_gap_next   = 1'b1;
                    up_stamp_next = timestamp;
                    if (dit_length_reg == '0)
                        dit_length_next = pulse;
                    else if (dah_length_reg == '0)
                    begin
                        dah_length_next = pulse;
                        if (close_enough(dit_length_reg, pulse, tolerance_reg))
                        begin
                            push           = 1'b1;
                            push_desc.kind = KIND_CAL_ERR;
                        end
                    end
                    else if (close_enough(dit_length_reg, pulse, tolerance_reg))
                    begin
                        node_index_next = step_tree(node_index_reg, 1'b0);
                        end_sent_next   = 1'b0;
                    end
                    else if (close_enough(dah_length_reg, pulse, tolerance_reg))
                    begin
                        node_index_next = step_tree(node_index_reg, 1'b1);
                        end_sent_next   = 1'b0;
                    end
                    else
                    begin
                        push           = 1'b1;
                        push_desc.kind = KIND_INVALID;
                    end
                end
                OP_POLL:
                begin
                    if (in_gap_reg && !end_sent_reg &&
                        (gap >= dah_length_reg ||
                         close_enough(dah_length_reg, gap, tolerance_reg)))
                    begin
                        push                = 1'b1;
                        push_desc.kind      = KIND_CHAR;
                        push_desc.index     = node_index_reg;
                        push_desc.rel       = (node_index_reg == previous_index_reg);
                        previous_index_next = node_index_reg;
                        node_index_next     = '0;
                        end_sent_next       = 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tolerance_reg      <= TOL_RESET;
            down_stamp_reg     <= '0;
            up_stamp_reg       <= '0;
            dit_length_reg     <= '0;
            dah_length_reg     <= '0;
            in_gap_reg         <= 1'b0;
            end_sent_reg       <= 1'b0;
            node_index_reg     <= '0;
            previous_index_reg <= '0;
        end
        else
        begin
            if (cfg_wr_en)
                tolerance_reg <= cfg_wr_data;
            down_stamp_reg     <= down_stamp_next;
            up_stamp_reg       <= up_stamp_next;
            dit_length_reg     <= dit_length_next;
            dah_length_reg     <= dah_length_next;
            in_gap_reg         <= in_gap_next;
            end_sent_reg       <= end_sent_next;
            node_index_reg     <= node_index_next;
            previous_index_reg <= previous_index_next;
        end
    end

endmodule

// ===== design/mtd_back.sv =====
// Back end: expands queued outcomes into output words held in an output register.
`timescale 1ns / 1ps
module mtd_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           empty,
    input  mtd_pkg::desc_t head,
    output logic           pop,
    output logic           out_valid,
    input  logic           out_ready,
    output logic [1:0]     out_kind,
    output logic [7:0]     out_index,
    output logic           out_last
);
    import mtd_pkg::*;

    logic       valid_reg, valid_next;
    logic       phase_reg, phase_next;
    logic [1:0] kind_reg, kind_next;
    logic [7:0] index_reg, index_next;
    logic       last_reg, last_next;
    logic       load;

    assign load      = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_kind  = kind_reg;
    assign out_index = index_reg;
    assign out_last  = last_reg;

    always_comb
    begin
        valid_next = valid_reg;
        phase_next = phase_reg;
        kind_next  = kind_reg;
        index_next = index_reg;
        last_next  = last_reg;
        pop        = 1'b0;
        if (load)
        begin
            valid_next = !empty;
            if (!empty)
            begin
                if (head.rel && !phase_reg)
                begin
                    // Release marker goes out first; the entry stays for its main word.
                    kind_next  = KIND_RELEASE;
                    index_next = '0;
                    last_next  = 1'b0;
                    phase_next = 1'b1;
                end
                else
                begin
                    kind_next  = head.kind;
                    index_next = head.index;
                    last_next  = 1'b1;
                    phase_next = 1'b0;
                    pop        = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            phase_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg  <= kind_next;
        index_reg <= index_next;
        last_reg  <= last_next;
    end

endmodule

// ===== verif/tb.sv =====
// Self-checking testbench for the Morse key timing decoder.
`timescale 1ns / 1ps
module tb;
    import mtd_pkg::*;

    // The fourth event code has no meaning to the decoder and must be ignored.
    localparam logic [1:0] OP_UNUSED = 2'd3;

    typedef struct {
        logic [1:0] kind;
        logic [7:0] index;
        logic       last;
    } outcome_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [15:0] cfg_wr_data = 16'd0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = 24'd0;   // timestamp[15:0], wraps[17:16], zero pad
    logic [1:0]  s_axis_tuser = 2'd0;    // op[1:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;           // tree_index[7:0]
    logic [1:0]  m_axis_tuser;           // kind[1:0]
    logic        m_axis_tlast;

    morse_timing_decoder uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Predicted state of the decoder, kept in step with every accepted word.
    logic [15:0] tolerance_now = TOL_RESET;
    logic [15:0] down_at = 16'd0;
    logic [15:0] up_at = 16'd0;
    logic [15:0] dit_ticks = 16'd0;
    logic [15:0] dah_ticks = 16'd0;
    logic        key_released = 1'b0;
    logic        char_sent = 1'b0;
    logic [7:0]  tree_node = 8'd0;
    logic [7:0]  last_sent_node = 8'd0;

    outcome_t pending_results[$];
    int       mismatch_count = 0;
    int       words_sent = 0;
    bit       idle_on = 1'b1;
    int       stall_left = 0;

    // Stimulus bookkeeping: an absolute tick count from which stamps and wrap
    // counts are derived, and the calibrated key lengths chosen for this run.
    longint unsigned tick_now = 0;
    longint unsigned last_edge_tick = 0;
    int              key_dit;
    int              key_dah;
    logic [9:0]      last_pattern = 10'd0;
    int              last_symbols = 1;

    // Elapsed ticks; a wrap count that does not fit the two stamps saturates.
    function automatic logic [15:0] ticks_between(input logic [15:0] s, input logic [15:0] e,
                                                  input logic [1:0] w);
        if (e >= s && w == 2'd0)
            return e - s;
        if (e < s && w == 2'd1)
            return e - s;
        return 16'hFFFF;
    endfunction

    function automatic bit within_tol(input logic [15:0] x, input logic [15:0] y);
        logic [15:0] diff;
        diff = (x < y) ? y - x : x - y;
        return diff < tolerance_now;
    endfunction

    // A dit takes the left child, a dah the right; past the depth bound the
    // node sticks at the overflow marker until it is emitted.
    function automatic void descend(input bit is_dah);
        int next_node;
        if (tree_node == NODE_DEEP)
            return;
        next_node = int'(tree_node) * 2 + (is_dah ? 2 : 1);
        if (next_node > (2 << MAX_SYMBOLS) - 2 || next_node > 254)
            tree_node = NODE_DEEP;
        else
            tree_node = next_node[7:0];
    endfunction

    task automatic predict_event(input logic [1:0] op, input logic [15:0] ts,
                                 input logic [1:0] wr);
        outcome_t    caused[$];
        logic [15:0] len;
        case (op)
            OP_DOWN:
            begin
                key_released = 1'b0;
                down_at = ts;
            end
            OP_UP:
            begin
                len = ticks_between(down_at, ts, wr);
                key_released = 1'b1;
                up_at = ts;
                if (dit_ticks == 16'd0)
                    dit_ticks = len;
                else if (dah_ticks == 16'd0)
                begin
                    dah_ticks = len;
                    if (within_tol(dit_ticks, dah_ticks))
                        caused.push_back('{KIND_CAL_ERR, 8'd0, 1'b0});
                end
                else if (within_tol(dit_ticks, len))
                begin
                    descend(1'b0);
                    char_sent = 1'b0;
                end
                else if (within_tol(dah_ticks, len))
                begin
                    descend(1'b1);
                    char_sent = 1'b0;
                end
                else
                    caused.push_back('{KIND_INVALID, 8'd0, 1'b0});
            end
            OP_POLL:
            begin
                if (key_released && !char_sent)
                begin
                    len = ticks_between(up_at, ts, wr);
                    if (len >= dah_ticks || within_tol(dah_ticks, len))
                    begin
                        if (tree_node == last_sent_node)
                            caused.push_back('{KIND_RELEASE, 8'd0, 1'b0});
                        caused.push_back('{KIND_CHAR, tree_node, 1'b0});
                        last_sent_node = tree_node;
                        tree_node = 8'd0;
                        char_sent = 1'b1;
                    end
                end
            end
            default:
                ;
        endcase
        if (caused.size() != 0)
            caused[caused.size() - 1].last = 1'b1;
        foreach (caused[i])
            pending_results.push_back(caused[i]);
    endtask

    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= 100)
            $display("[%0t] mismatch: %s", $time, what);
    endtask

    // Result side: every word taken from the decoder is held against the
    // oldest prediction still waiting.
    always @(posedge clk)
    begin
        outcome_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_results.size() == 0)
                report_mismatch($sformatf("unexpected word kind %0d index %0d last %0b",
                                          m_axis_tuser, m_axis_tdata, m_axis_tlast));
            else
            begin
                want = pending_results.pop_front();
                if (m_axis_tuser !== want.kind)
                    report_mismatch($sformatf("kind %0d, wanted %0d",
                                              m_axis_tuser, want.kind));
                if (m_axis_tdata !== want.index)
                    report_mismatch($sformatf("tree index %0d, wanted %0d",
                                              m_axis_tdata, want.index));
                if (m_axis_tlast !== want.last)
                    report_mismatch($sformatf("last %0b, wanted %0b",
                                              m_axis_tlast, want.last));
            end
        end
    end

    // Receiver stalls come in bursts, each begun only while idle insertion is on.
    always @(posedge clk)
    begin
        if (stall_left != 0)
        begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end
        else if (idle_on && $urandom_range(0, 5) == 0)
        begin
            stall_left = $urandom_range(0, 7);
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= 1'b1;
    end

    // Offers one event word and returns once the decoder has taken it. The
    // valid stays high into the next word unless an idle burst is drawn.
    task automatic send_word(input logic [1:0] op, input logic [15:0] ts,
                             input logic [1:0] wr);
        int hold;
        if (idle_on && $urandom_range(0, 4) == 0)
        begin
            hold = $urandom_range(1, 8);
            s_axis_tvalid <= 1'b0;
            repeat (hold) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {6'd0, wr, ts};
        s_axis_tuser <= op;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        predict_event(op, ts, wr);
        words_sent++;
    endtask

    // Moves the tick count on and sends an event stamped with it; the wrap
    // count is measured from the previous key edge.
    task automatic key_event(input logic [1:0] op, input int delta);
        longint unsigned wrapped;
        tick_now += 64'(delta);
        wrapped = (tick_now >> 16) - (last_edge_tick >> 16);
        if (wrapped > 2)
            wrapped = 2;
        send_word(op, tick_now[15:0], wrapped[1:0]);
        if (op != OP_POLL)
            last_edge_tick = tick_now;
    endtask

    // Holds the input off until every predicted word has come out, then
    // lets events that produce nothing pass as well.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_tolerance(input logic [15:0] value);
        settle();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        tolerance_now = value;
    endtask

    // A length near the base, kept inside the current tolerance where it can be.
    function automatic int jittered(input int base);
        int spread;
        spread = (tolerance_now == 16'd0) ? 0 : int'(tolerance_now) - 1;
        if (spread > base / 4)
            spread = base / 4;
        return base - spread + int'($urandom_range(0, 2 * spread));
    endfunction

    // One keyed character: its symbols with gaps of about a dit between them,
    // now and then a poll inside such a gap, then a letter gap and its polls.
    task automatic send_character(input int symbols, input logic [9:0] pattern);
        int len;
        int gap;
        for (int i = 0; i < symbols; i++)
        begin
            gap = (i == 0) ? $urandom_range(1, key_dit) : jittered(key_dit);
            if (i != 0 && $urandom_range(0, 3) == 0)
            begin
                key_event(OP_POLL, gap / 2);
                gap = gap - gap / 2;
            end
            key_event(OP_DOWN, gap);
            case ($urandom_range(0, 19))
                0: len = $urandom_range(0, 4 * key_dah);
                1: len = $urandom_range(65536, 140000);
                default: len = jittered(pattern[i] ? key_dah : key_dit);
            endcase
            key_event(OP_UP, len);
        end
        gap = key_dah + $urandom_range(0, key_dah);
        if ($urandom_range(0, 19) == 0)
            gap = $urandom_range(60000, 140000);
        if ($urandom_range(0, 2) == 0)
        begin
            key_event(OP_POLL, key_dit);
            gap = gap - key_dit;
        end
        key_event(OP_POLL, gap);
        if ($urandom_range(0, 4) == 0)
            key_event(OP_POLL, $urandom_range(1, key_dah));
    endtask

    // Calibration: the zero-length pulse, a poll with no dah length yet, and
    // a dah that the wide-open tolerance makes look like a dit.
    task automatic test_calibration();
        write_tolerance(16'hFFFF);
        key_event(OP_POLL, 5);
        key_event(OP_DOWN, 20);
        key_event(OP_UP, 0);
        key_event(OP_POLL, 3);
        key_event(OP_DOWN, 50);
        key_event(OP_UP, key_dit);
        send_word(OP_UNUSED, 16'($urandom), 2'($urandom_range(0, 3)));
        key_event(OP_DOWN, 40);
        key_event(OP_UP, 0);
        key_event(OP_DOWN, 40);
        key_event(OP_UP, key_dah);
    endtask

    // A dit, a dah and a pulse matching neither; a poll too early in the gap,
    // then a pause until the decoder has drained before the letter poll.
    task automatic test_classification();
        write_tolerance(16'(key_dit / 2));
        key_event(OP_DOWN, 2 * key_dah);
        key_event(OP_UP, key_dit);
        key_event(OP_DOWN, key_dit);
        key_event(OP_UP, key_dah);
        key_event(OP_DOWN, key_dit);
        key_event(OP_UP, 2 * key_dit);
        key_event(OP_POLL, key_dit);
        settle();
        key_event(OP_POLL, key_dah);
    endtask

    // A pulse across one counter wrap, a long poll, a wrap count of three and
    // a wrap count that contradicts the stamps.
    task automatic test_wrap_rules();
        key_event(OP_DOWN, 131064 - int'(tick_now[15:0]));
        key_event(OP_UP, key_dit);
        key_event(OP_POLL, 70000);
        send_word(OP_DOWN, 16'h0000, 2'd3);
        send_word(OP_UP, 16'hFFFF, 2'd1);
    endtask

    // Characters at and past the depth bound.
    task automatic test_tree_depth();
        send_character(7, 10'h3FF);
        send_character(8, 10'($urandom));
        send_character(9, 10'h000);
    endtask

    // Mostly well-formed characters with random symbols, some repeated to
    // provoke release words, mixed with random noise words.
    task automatic test_random_phase(input logic [15:0] tol, input int words, input bit idle);
        int target;
        write_tolerance(tol);
        idle_on = idle;
        target = words_sent + words;
        while (words_sent < target)
        begin
            if ($urandom_range(0, 9) == 0)
                send_word(2'($urandom_range(0, 3)), 16'($urandom),
                          2'($urandom_range(0, 3)));
            else
            begin
                if ($urandom_range(0, 3) != 0)
                begin
                    last_symbols = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 9)
                                                               : $urandom_range(1, 5);
                    last_pattern = 10'($urandom);
                    if (last_symbols >= 6 && $urandom_range(0, 2) == 0)
                        last_pattern = 10'h3FF;
                end
                send_character(last_symbols, last_pattern);
            end
        end
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        key_dit = $urandom_range(40, 400);
        key_dah = 3 * key_dit;
        test_calibration();
        test_classification();
        test_wrap_rules();
        test_random_phase(16'(key_dit / 2), 250, 1'b1);
        test_tree_depth();
        test_random_phase(16'd1, 150, 1'b1);
        test_random_phase(16'd0, 120, 1'b1);
        test_random_phase(16'hFFFF, 120, 1'b1);
        test_random_phase(16'($urandom_range(0, 65535)), 200, 1'b1);
        test_random_phase(16'(key_dit / 2), 250, 1'b0);
        settle();
        repeat (20) @(posedge clk);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("PASS morse_timing_decoder");
        else
            $display("FAIL morse_timing_decoder");
        $finish;
    end

    // Watchdog, far beyond the slowest correct run.
    initial
    begin
        #6000000;
        $display("FAIL morse_timing_decoder");
        $finish;
    end

endmodule
